// ----- sv/fmis_pkg.sv -----
package fmis_pkg;

    // field widths
    localparam int IDX_W   = 4;
    localparam int POS_W   = 16;
    localparam int MEMB_W  = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_A_W = 3;

    // breakpoint registers per set
    localparam int REGS_PER_SET = 3;

    // default sweep and breakpoint count
    localparam int STEPS_DEF  = 10;
    localparam int POINTS_DEF = 3;

    // membership of one in Q1.15
    localparam logic [MEMB_W-1:0] MEMB_ONE = 16'h8000;

    // register reset values
    localparam logic [CFG_W-1:0] RST_A_FIRST  = 32'h0000_0000;
    localparam logic [CFG_W-1:0] RST_A_MIDDLE = 32'h8000_0300;
    localparam logic [CFG_W-1:0] RST_A_FINAL  = 32'h0000_0500;
    localparam logic [CFG_W-1:0] RST_B_FIRST  = 32'h0000_0300;
    localparam logic [CFG_W-1:0] RST_B_MIDDLE = 32'h8000_0500;
    localparam logic [CFG_W-1:0] RST_B_FINAL  = 32'h0000_0800;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_A_FIRST  = 3'd0,
        REG_A_MIDDLE = 3'd1,
        REG_A_FINAL  = 3'd2,
        REG_B_FIRST  = 3'd3,
        REG_B_MIDDLE = 3'd4,
        REG_B_FINAL  = 3'd5
    } t_cfg_reg;

    // breakpoint position, Q8.8 signed
    function automatic logic signed [POS_W-1:0] pos_of(input logic [CFG_W-1:0] r);
        return signed'(r[POS_W-1:0]);
    endfunction

    // breakpoint membership, saturated to one
    function automatic logic [MEMB_W-1:0] memb_of(input logic [CFG_W-1:0] r);
        logic [MEMB_W-1:0] m;
        m = r[CFG_W-1:POS_W];
        return (m > MEMB_ONE) ? MEMB_ONE : m;
    endfunction

endpackage

// ----- sv/fmis_smp_if.sv -----
interface fmis_smp_if import fmis_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

// ----- sv/fmis_res_if.sv -----
interface fmis_res_if import fmis_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  x_position;
    logic        [MEMB_W-1:0] membership_a;
    logic        [MEMB_W-1:0] membership_b;
    logic        [MEMB_W-1:0] membership_min;

    modport source (output valid, output x_position, output membership_a,
                    output membership_b, output membership_min, input ready);
    modport sink   (input valid, input x_position, input membership_a,
                    input membership_b, input membership_min, output ready);
endinterface

// ----- sv/fuzzy_min_intersection_sampler.sv -----
// Fuzzy set intersection sampler.
// Two piecewise-linear fuzzy sets (three breakpoints each, Q8.8 position in
// bits 15:0 and Q1.15 membership in bits 31:16) sit in six registers written
// through i_cfg_we / i_cfg_idx / i_cfg_data; write them only while the block
// is idle. Each transfer on i_smp carries a sample index of the sweep from
// the lowest first breakpoint to the highest last breakpoint in STEPS steps.
// Each transfer on o_res returns the sample position, the membership in
// both sets and the smaller of the two.
// Pipeline: 21 register stages; three stages build the position (span
// multiply, reciprocal multiply, add), one picks the segment and forms the
// interpolation product, sixteen run a one-bit-per-stage restoring divider
// for each set, one forms the outputs.
// Throughput: one item per cycle while o_res.ready is high; every stage
// holds its own valid bit.
// Stall: when o_res.ready is low, stages close up behind the held result and
// input is taken until every stage is full; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the
// default breakpoints.
module fuzzy_min_intersection_sampler import fmis_pkg::*; #(
    parameter int STEPS  = STEPS_DEF,
    parameter int POINTS = POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    fmis_smp_if.sink           i_smp,
    fmis_res_if.source         o_res
);

    // breakpoints in use
    localparam int NP = (POINTS < 2) ? 2 : ((POINTS > REGS_PER_SET) ? REGS_PER_SET : POINTS);

    // sweep position: |index * span| < 2^MAG_W, divided by reciprocal multiply
    localparam int SPAN_W    = POS_W + 1;
    localparam int PROD_W    = IDX_W + 1 + SPAN_W;
    localparam int MAG_W     = IDX_W + POS_W;
    localparam int RECIP_W   = MAG_W + 2;
    localparam int DIV_SHIFT = MAG_W + $clog2(STEPS);
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << DIV_SHIFT) + longint'(STEPS) - 1) / longint'(STEPS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int SCL_W = MAG_W + RECIP_W;

    // interpolation divider
    localparam int NUM_W     = 2 * MEMB_W;
    localparam int DIV_STEPS = MEMB_W;

    // stage count: position (3), segment select (1), divider, output (1)
    localparam int NST = DIV_STEPS + 5;
    localparam int SEG = 3;

    typedef struct packed {
        logic signed [POS_W-1:0]  xmin;
        logic signed [PROD_W-1:0] prod;
    } t_s1;

    typedef struct packed {
        logic signed [POS_W-1:0] xmin;
        logic                    neg;
        logic [SCL_W-1:0]        scaled;
    } t_s2;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [MEMB_W-1:0] den;
        logic [MEMB_W-1:0] quo;
        logic [MEMB_W-1:0] base;
    } t_lane;

    typedef struct packed {
        logic signed [POS_W-1:0] xc;
        t_lane                   la;
        t_lane                   lb;
    } t_div;

    typedef struct packed {
        logic signed [POS_W-1:0] xc;
        logic [MEMB_W-1:0]       ua;
        logic [MEMB_W-1:0]       ub;
        logic [MEMB_W-1:0]       um;
    } t_out;

    logic [REGS_PER_SET-1:0][CFG_W-1:0] r_pts_a;
    logic [REGS_PER_SET-1:0][CFG_W-1:0] r_pts_b;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_en;

    t_s1                    r_s1, n_s1;
    t_s2                    r_s2, n_s2;
    logic signed [POS_W-1:0] r_xc, n_xc;
    t_div                   r_div [DIV_STEPS+1];
    t_div                   n_div [DIV_STEPS+1];
    t_out                   r_out, n_out;

    // segment select and interpolation operands for one set
    function automatic t_lane seg_eval(input logic signed [POS_W-1:0] xc,
                                       input logic [REGS_PER_SET-1:0][CFG_W-1:0] p);
        t_lane             l;
        logic              found;
        logic [SPAN_W-1:0] dx;
        logic [SPAN_W-1:0] t;
        logic [MEMB_W-1:0] dy;
        logic [MEMB_W-1:0] y0;
        logic [MEMB_W-1:0] y1;
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] x1;
        l     = '0;
        l.den = MEMB_W'(1);
        l.base = memb_of(p[NP-1]);
        t     = '0;
        dy    = '0;
        found = 1'b0;
        if (xc < pos_of(p[0])) begin
            l.base = memb_of(p[0]);
            found  = 1'b1;
        end
        for (int i = 0; i < NP - 1; i++) begin
            x0 = pos_of(p[i]);
            x1 = pos_of(p[i+1]);
            y0 = memb_of(p[i]);
            y1 = memb_of(p[i+1]);
            if (!found && xc >= x0 && xc <= x1) begin
                found = 1'b1;
                dx    = {x1[POS_W-1], x1} - {x0[POS_W-1], x0};
                if (dx == '0 || y0 == y1) begin
                    l.base = y0;
                end else if (y0 < y1) begin
                    l.base = y0;
                    l.den  = dx[MEMB_W-1:0];
                    t      = {xc[POS_W-1], xc} - {x0[POS_W-1], x0};
                    dy     = y1 - y0;
                end else begin
                    l.base = y1;
                    l.den  = dx[MEMB_W-1:0];
                    t      = {x1[POS_W-1], x1} - {xc[POS_W-1], xc};
                    dy     = y0 - y1;
                end
            end
        end
        l.rem = {{(NUM_W-MEMB_W){1'b0}}, t[MEMB_W-1:0]} * {{(NUM_W-MEMB_W){1'b0}}, dy};
        return l;
    endfunction

    // one restoring division step at quotient bit b
    function automatic t_lane div_step(input t_lane l, input int b);
        t_lane            o;
        logic [NUM_W:0]   trial;
        o     = l;
        trial = {1'b0, l.rem} - ({{(NUM_W+1-MEMB_W){1'b0}}, l.den} << b);
        if (!trial[NUM_W]) begin
            o.rem    = trial[NUM_W-1:0];
            o.quo[b] = 1'b1;
        end
        return o;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts_a <= {RST_A_FINAL, RST_A_MIDDLE, RST_A_FIRST};
            r_pts_b <= {RST_B_FINAL, RST_B_MIDDLE, RST_B_FIRST};
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_A_FIRST:  r_pts_a[0] <= i_cfg_data;
                REG_A_MIDDLE: r_pts_a[1] <= i_cfg_data;
                REG_A_FINAL:  r_pts_a[2] <= i_cfg_data;
                REG_B_FIRST:  r_pts_b[0] <= i_cfg_data;
                REG_B_MIDDLE: r_pts_b[1] <= i_cfg_data;
                REG_B_FINAL:  r_pts_b[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        n_en[NST-1] = !r_vld[NST-1] || o_res.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign i_smp.ready = n_en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= (k == 0) ? i_smp.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage 1: sweep bounds and index times span
    always_comb begin
        logic [IDX_W-1:0]        idx_c;
        logic signed [POS_W-1:0] xmin;
        logic signed [POS_W-1:0] xmax;
        logic signed [SPAN_W-1:0] span;
        idx_c = (int'(i_smp.sample_index) > STEPS) ? IDX_W'(STEPS) : i_smp.sample_index;
        xmin  = (pos_of(r_pts_b[0]) < pos_of(r_pts_a[0])) ? pos_of(r_pts_b[0])
                                                            : pos_of(r_pts_a[0]);
        xmax  = (pos_of(r_pts_b[NP-1]) > pos_of(r_pts_a[NP-1])) ? pos_of(r_pts_b[NP-1])
                                                                  : pos_of(r_pts_a[NP-1]);
        span  = {xmax[POS_W-1], xmax} - {xmin[POS_W-1], xmin};
        n_s1.xmin = xmin;
        n_s1.prod = PROD_W'(signed'({1'b0, idx_c})) * PROD_W'(span);
    end

    // stage 2: magnitude times reciprocal of the step count
    always_comb begin
        logic [PROD_W-1:0] mag;
        mag         = r_s1.prod[PROD_W-1] ? PROD_W'(-r_s1.prod) : PROD_W'(r_s1.prod);
        n_s2.xmin   = r_s1.xmin;
        n_s2.neg    = r_s1.prod[PROD_W-1];
        n_s2.scaled = {{RECIP_W{1'b0}}, mag[MAG_W-1:0]} * {{MAG_W{1'b0}}, RECIP};
    end

    // stage 3: truncated quotient back to a signed offset, plus the sweep start
    always_comb begin
        logic [MAG_W-1:0]        q;
        logic signed [MAG_W:0]   qs;
        logic signed [MAG_W:0]   sum;
        q    = MAG_W'(r_s2.scaled >> DIV_SHIFT);
        qs   = r_s2.neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
        sum  = {{(MAG_W+1-POS_W){r_s2.xmin[POS_W-1]}}, r_s2.xmin} + qs;
        n_xc = sum[POS_W-1:0];
    end

    // stage 4 and divider stages
    always_comb begin
        n_div[0].xc = r_xc;
        n_div[0].la = seg_eval(r_xc, r_pts_a);
        n_div[0].lb = seg_eval(r_xc, r_pts_b);
        for (int j = 1; j <= DIV_STEPS; j++) begin
            n_div[j].xc = r_div[j-1].xc;
            n_div[j].la = div_step(r_div[j-1].la, DIV_STEPS - j);
            n_div[j].lb = div_step(r_div[j-1].lb, DIV_STEPS - j);
        end
    end

    // output stage: add base and take the minimum
    always_comb begin
        n_out.xc = r_div[DIV_STEPS].xc;
        n_out.ua = r_div[DIV_STEPS].la.base + r_div[DIV_STEPS].la.quo;
        n_out.ub = r_div[DIV_STEPS].lb.base + r_div[DIV_STEPS].lb.quo;
        n_out.um = (n_out.ua < n_out.ub) ? n_out.ua : n_out.ub;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_s1 <= n_s1;
        end
        if (n_en[1]) begin
            r_s2 <= n_s2;
        end
        if (n_en[2]) begin
            r_xc <= n_xc;
        end
        for (int j = 0; j <= DIV_STEPS; j++) begin
            if (n_en[SEG + j]) begin
                r_div[j] <= n_div[j];
            end
        end
        if (n_en[NST-1]) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid          = r_vld[NST-1];
    assign o_res.x_position     = r_out.xc;
    assign o_res.membership_a   = r_out.ua;
    assign o_res.membership_b   = r_out.ub;
    assign o_res.membership_min = r_out.um;

endmodule

// ----- sv/fmis_checker.sv -----
module fmis_checker import fmis_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_res_valid,
    input logic                     i_res_ready,
    input logic signed [POS_W-1:0]  i_x_position,
    input logic        [MEMB_W-1:0] i_membership_a,
    input logic        [MEMB_W-1:0] i_membership_b,
    input logic        [MEMB_W-1:0] i_membership_min
);

    // intersection is the smaller membership
    a_min_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_membership_min ==
            ((i_membership_a < i_membership_b) ? i_membership_a : i_membership_b))
        else $error("membership_min is not the smaller membership");

    // interpolation never exceeds one
    a_memb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_membership_a <= MEMB_ONE) && (i_membership_b <= MEMB_ONE))
        else $error("membership above one");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_x_position)
            && $stable(i_membership_min))
        else $error("stalled result changed");

endmodule

bind fuzzy_min_intersection_sampler fmis_checker u_fmis_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_x_position     (o_res.x_position),
    .i_membership_a   (o_res.membership_a),
    .i_membership_b   (o_res.membership_b),
    .i_membership_min (o_res.membership_min)
);

// ----- test/fuzzy_min_intersection_sampler_tb.sv -----
`timescale 1ns / 1ps

module fuzzy_min_intersection_sampler_tb;
    import fmis_pkg::*;

    localparam int SWEEP_STEPS  = STEPS_DEF;
    localparam int SET_POINTS   = POINTS_DEF;
    localparam int GRADE_ONE    = int'(MEMB_ONE);
    localparam int PIPE_SLACK   = 30;
    localparam int RANDOM_ITEMS = 1470;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct packed {
        logic signed [POS_W-1:0] x_pos;
        logic [MEMB_W-1:0]       grade_a;
        logic [MEMB_W-1:0]       grade_b;
        logic [MEMB_W-1:0]       grade_min;
    } t_sample_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    fmis_smp_if smp_bus ();
    fmis_res_if res_bus ();

    // breakpoint registers as the block should hold them
    logic [CFG_W-1:0] breakpoint_regs [2*REGS_PER_SET] = '{
        RST_A_FIRST, RST_A_MIDDLE, RST_A_FINAL, RST_B_FIRST, RST_B_MIDDLE, RST_B_FINAL
    };

    t_sample_result expected_samples [$];
    bit             idle_on = 1'b0;
    int             mismatch_count  = 0;
    int             samples_sent    = 0;
    int             results_checked = 0;
    int             settings_loaded = 0;
    int             cycle_count     = 0;
    int             stall_left      = 0;

    fuzzy_min_intersection_sampler #(
        .STEPS  (SWEEP_STEPS),
        .POINTS (SET_POINTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_bus.sink),
        .o_res      (res_bus.source)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // signed Q8.8 position of a breakpoint word
    function automatic int point_pos(input logic [CFG_W-1:0] word);
        return int'($signed(word[POS_W-1:0]));
    endfunction

    // Q1.15 membership of a breakpoint word, capped at one
    function automatic int point_grade(input logic [CFG_W-1:0] word);
        int grade;
        grade = int'(word[CFG_W-1:POS_W]);
        return (grade > GRADE_ONE) ? GRADE_ONE : grade;
    endfunction

    function automatic logic [CFG_W-1:0] pack_point(input int pos, input int grade);
        return {grade[MEMB_W-1:0], pos[POS_W-1:0]};
    endfunction

    // piecewise-linear membership at xc, truncating interpolation
    function automatic int grade_at(input int xc, input logic [CFG_W-1:0] pts [REGS_PER_SET],
                                    input int np);
        int x0, x1, y0, y1;
        if (xc < point_pos(pts[0])) return point_grade(pts[0]);
        for (int i = 0; i < np - 1; i++) begin
            x0 = point_pos(pts[i]);
            x1 = point_pos(pts[i+1]);
            y0 = point_grade(pts[i]);
            y1 = point_grade(pts[i+1]);
            if (xc >= x0 && xc <= x1) begin
                if (x1 <= x0 || y0 == y1) return y0;
                if (y0 < y1) return y0 + int'(longint'(xc - x0) * (y1 - y0) / (x1 - x0));
                return y1 + int'(longint'(x1 - xc) * (y0 - y1) / (x1 - x0));
            end
        end
        return point_grade(pts[np-1]);
    endfunction

    // expected position and memberships for one sample index
    function automatic t_sample_result predict_sample(input logic [IDX_W-1:0] idx);
        logic [CFG_W-1:0] set_a [REGS_PER_SET];
        logic [CFG_W-1:0] set_b [REGS_PER_SET];
        int np, step, lo, hi, xc, ga, gb;
        t_sample_result res;
        np = (SET_POINTS < 2) ? 2 : (SET_POINTS > REGS_PER_SET) ? REGS_PER_SET : SET_POINTS;
        for (int i = 0; i < REGS_PER_SET; i++) begin
            set_a[i] = breakpoint_regs[i];
            set_b[i] = breakpoint_regs[REGS_PER_SET+i];
        end
        step = (int'(idx) > SWEEP_STEPS) ? SWEEP_STEPS : int'(idx);
        lo = point_pos(set_a[0]);
        if (point_pos(set_b[0]) < lo) lo = point_pos(set_b[0]);
        hi = point_pos(set_a[np-1]);
        if (point_pos(set_b[np-1]) > hi) hi = point_pos(set_b[np-1]);
        // quotient truncates toward zero, also on a downward sweep
        xc = lo + int'(longint'(step) * (hi - lo) / SWEEP_STEPS);
        ga = grade_at(xc, set_a, np);
        gb = grade_at(xc, set_b, np);
        res.x_pos     = xc[POS_W-1:0];
        res.grade_a   = ga[MEMB_W-1:0];
        res.grade_b   = gb[MEMB_W-1:0];
        res.grade_min = (ga < gb) ? ga[MEMB_W-1:0] : gb[MEMB_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("mismatch on %s at result %0d: expected %0d, got %0d",
                 what, results_checked, want, got);
        mismatch_count++;
    endtask

    // input side: predict each transfer as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && smp_bus.valid && smp_bus.ready) begin
            expected_samples.push_back(predict_sample(smp_bus.sample_index));
            samples_sent++;
        end
    end

    // output side: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_sample_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_samples.size() == 0) begin
                flag_mismatch("unexpected result", 0, int'(res_bus.x_position));
            end else begin
                want = expected_samples.pop_front();
                if (res_bus.x_position !== want.x_pos)
                    flag_mismatch("x_position", int'(want.x_pos), int'(res_bus.x_position));
                if (res_bus.membership_a !== want.grade_a)
                    flag_mismatch("membership_a", int'(want.grade_a), int'(res_bus.membership_a));
                if (res_bus.membership_b !== want.grade_b)
                    flag_mismatch("membership_b", int'(want.grade_b), int'(res_bus.membership_b));
                if (res_bus.membership_min !== want.grade_min)
                    flag_mismatch("membership_min", int'(want.grade_min),
                                  int'(res_bus.membership_min));
                results_checked++;
            end
        end
    end

    // result ready with random stall bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_samples.size());
        $display("CHECK FAILED");
        $finish;
    end

    // one sample transfer, with an optional gap before it
    task automatic send_sample(input logic [IDX_W-1:0] idx);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            smp_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_bus.valid        <= 1'b1;
        smp_bus.sample_index <= idx;
        @(posedge i_clk);
        while (!smp_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [IDX_W-1:0] random_index();
        if ($urandom_range(0, 4) == 0) return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        return IDX_W'($urandom_range(0, SWEEP_STEPS));
    endfunction

    // stop input and wait until every result is back
    task automatic drain_pipeline();
        smp_bus.valid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (PIPE_SLACK) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg which, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= which;
        i_cfg_data <= value;
        breakpoint_regs[int'(which)] = value;
        @(negedge i_clk);
    endtask

    // new breakpoints for both sets, only once the block is idle
    task automatic load_sets(input logic [CFG_W-1:0] a0, a1, a2, b0, b1, b2);
        drain_pipeline();
        write_reg(REG_A_FIRST,  a0);
        write_reg(REG_A_MIDDLE, a1);
        write_reg(REG_A_FINAL,  a2);
        write_reg(REG_B_FIRST,  b0);
        write_reg(REG_B_MIDDLE, b1);
        write_reg(REG_B_FINAL,  b2);
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // mostly ascending sets, sometimes full-range extremes or raw words
    function automatic void random_set(input int base, input int span,
                                       output logic [CFG_W-1:0] pts [REGS_PER_SET]);
        int pick, pos, grade;
        pick = $urandom_range(0, 11);
        pos  = base;
        for (int i = 0; i < REGS_PER_SET; i++) begin
            if (pick == 0) begin
                pts[i] = $urandom;
            end else begin
                if (pick == 1)
                    pos = (i == 0) ? -32768 : (i == REGS_PER_SET - 1) ? 32767 :
                          $urandom_range(0, 65535) - 32768;
                else if (i > 0)
                    pos = pos + $urandom_range(0, span);
                if (pos < -32768) pos = -32768;
                if (pos > 32767) pos = 32767;
                case ($urandom_range(0, 9))
                    0:       grade = 0;
                    1:       grade = GRADE_ONE;
                    2:       grade = $urandom_range(GRADE_ONE + 1, 65535);
                    default: grade = $urandom_range(0, GRADE_ONE);
                endcase
                pts[i] = pack_point(pos, grade);
            end
        end
    endfunction

    task automatic load_random_sets();
        int base, span;
        logic [CFG_W-1:0] a [REGS_PER_SET];
        logic [CFG_W-1:0] b [REGS_PER_SET];
        case ($urandom_range(0, 3))
            0:       span = 16;
            1:       span = 600;
            2:       span = 8000;
            default: span = 32767;
        endcase
        base = $urandom_range(0, 65535) - 32768;
        random_set(base, span, a);
        // set b starts near set a so the sweep crosses both
        random_set(base + $urandom_range(0, span) - span / 2, span, b);
        load_sets(a[0], a[1], a[2], b[0], b[1], b[2]);
    endtask

    // default breakpoints after reset, every sweep index and the largest index
    task automatic test_reset_sweep();
        for (int i = 0; i <= SWEEP_STEPS; i++) send_sample(IDX_W'(i));
        send_sample(IDX_W'((1 << IDX_W) - 1));
    endtask

    // positions at both ends, zero and full grades, grade above one
    task automatic test_extreme_points();
        load_sets(pack_point(-32768, 0), pack_point(0, GRADE_ONE), pack_point(32767, 0),
                  pack_point(-32768, 65535), pack_point(-32768, 0),
                  pack_point(32767, GRADE_ONE));
        send_sample(0);
        send_sample(1);
        send_sample(5);
        send_sample(IDX_W'(SWEEP_STEPS));
    endtask

    // descending set, flat and zero-width segments, downward sweep
    task automatic test_odd_shapes();
        load_sets(pack_point('h400, 16384), pack_point('h100, 16384),
                  pack_point(-'h200, 8000),
                  pack_point('h200, 20000), pack_point('h200, 20000),
                  pack_point(-'h100, 100));
        send_sample(0);
        send_sample(3);
        send_sample(7);
        send_sample(IDX_W'(SWEEP_STEPS));
    endtask

    // random breakpoints, random indices, idling on most phases
    task automatic test_random_sets();
        int sent, burst;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            load_random_sets();
            idle_on = ($urandom_range(0, 5) != 0);
            burst   = $urandom_range(20, 60);
            repeat (burst) begin
                send_sample(random_index());
                sent++;
            end
        end
    endtask

    // back-to-back transfers with no idling on either side
    task automatic test_full_rate();
        idle_on = 1'b0;
        load_random_sets();
        for (int i = 0; i < 64; i++) send_sample(IDX_W'(i));
        load_random_sets();
        for (int i = 0; i < 16; i++) send_sample(random_index());
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        smp_bus.valid        = 1'b0;
        smp_bus.sample_index = '0;
        res_bus.ready        = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_sweep();
        test_extreme_points();
        test_odd_shapes();
        idle_on = 1'b1;
        test_random_sets();
        test_full_rate();
        drain_pipeline();

        $display("swept %0d samples over %0d breakpoint settings plus reset defaults",
                 samples_sent, settings_loaded);
        $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/fmis_pkg.sv
sv/fmis_smp_if.sv
sv/fmis_res_if.sv
sv/fuzzy_min_intersection_sampler.sv
sv/fmis_checker.sv
test/fuzzy_min_intersection_sampler_tb.sv
